### sv/mpmc_pkg.sv
// ----------------------------------------------------------------------------
// mpmc_pkg
// Shared types and constants for the multi-pattern match counter.
// ----------------------------------------------------------------------------
package mpmc_pkg;

    localparam int NODES    = 1024;
    localparam int ALPHABET = 128;
    localparam int NODE_W   = $clog2(NODES);
    localparam int SYM_W    = $clog2(ALPHABET);
    localparam int CNT_W    = NODE_W + 1;
    localparam int G_AW     = NODE_W + SYM_W;
    localparam int SUM_W    = NODE_W + 16;

    typedef enum logic [2:0] {
        ACT_CLEAR    = 3'd0,
        ACT_INSERT   = 3'd1,
        ACT_END_PAT  = 3'd2,
        ACT_BUILD    = 3'd3,
        ACT_SCAN     = 3'd4,
        ACT_END_TEXT = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_PHASE = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0] action;
        logic [6:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] matches_here;
        logic [31:0] text_total;
        logic [10:0] nodes_used;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLR_ZERO,
        OP_CLR_FIN,
        OP_INS_RD,
        OP_INS_STEP,
        OP_INS_ALLOC,
        OP_ROW_ZERO,
        OP_EP_RD,
        OP_EP_WR,
        OP_ICUR0,
        OP_B_INIT,
        OP_B_ROOT_RD,
        OP_B_ROOT_WR,
        OP_B_POP,
        OP_B_U,
        OP_B_F,
        OP_B_RD,
        OP_B_WR,
        OP_SC_RD,
        OP_SC_T,
        OP_SC_ACC_RD,
        OP_SC_ACC,
        OP_SC_FIN,
        OP_RESP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] status;
        logic       end_text;
    } t_cmd;

    typedef struct packed {
        logic rd_zero;
        logic full;
        logic cnt_last;
        logic q_more;
        logic t_zero;
    } t_dstat;

endpackage

### sv/mpmc_ctrl.sv
// ----------------------------------------------------------------------------
// mpmc_ctrl
// Sequencer: decodes the accepted word and steps the datapath through each
// action. Holds the phase flags.
// ----------------------------------------------------------------------------
module mpmc_ctrl
    import mpmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_action,
    input  t_dstat     i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_DISP      = 18'h00002,
        S_CLR       = 18'h00004,
        S_CLR_FIN   = 18'h00008,
        S_INS_CHK   = 18'h00010,
        S_ROW_ZERO  = 18'h00020,
        S_EP_WR     = 18'h00040,
        S_B_ROOT_RD = 18'h00080,
        S_B_ROOT_WR = 18'h00100,
        S_B_POP     = 18'h00200,
        S_B_U       = 18'h00400,
        S_B_F       = 18'h00800,
        S_B_RD      = 18'h01000,
        S_B_WR      = 18'h02000,
        S_SC_T      = 18'h04000,
        S_SC_CHK    = 18'h08000,
        S_SC_ACC    = 18'h10000,
        S_RESP      = 18'h20000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_action, n_action;
    logic [1:0] r_status, n_status;
    logic       r_end_text, n_end_text;
    logic       r_built, n_built;
    logic       r_drop, n_drop;
    t_op        op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_action   <= ACT_CLEAR;
            r_status   <= ST_OK;
            r_end_text <= 1'b0;
            r_built    <= 1'b0;
            r_drop     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_action   <= n_action;
            r_status   <= n_status;
            r_end_text <= n_end_text;
            r_built    <= n_built;
            r_drop     <= n_drop;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_action   = r_action;
        n_status   = r_status;
        n_end_text = r_end_text;
        n_built    = r_built;
        n_drop     = r_drop;
        op         = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    op         = OP_LATCH;
                    n_action   = i_action;
                    n_status   = ST_OK;
                    n_end_text = 1'b0;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_RESP;
                case (r_action)
                    ACT_CLEAR: n_state = S_CLR;
                    ACT_INSERT: begin
                        if (r_built) begin
                            n_status = ST_PHASE;
                        end else if (r_drop) begin
                            n_status = ST_FULL;
                        end else begin
                            op      = OP_INS_RD;
                            n_state = S_INS_CHK;
                        end
                    end
                    ACT_END_PAT: begin
                        if (r_built) begin
                            n_status = ST_PHASE;
                        end else if (r_drop) begin
                            n_status = ST_FULL;
                            n_drop   = 1'b0;
                            op       = OP_ICUR0;
                        end else begin
                            op      = OP_EP_RD;
                            n_state = S_EP_WR;
                        end
                    end
                    ACT_BUILD: begin
                        if (r_built) begin
                            n_status = ST_PHASE;
                        end else begin
                            op      = OP_B_INIT;
                            n_state = S_B_ROOT_RD;
                        end
                    end
                    ACT_SCAN: begin
                        if (!r_built) begin
                            n_status = ST_PHASE;
                        end else begin
                            op      = OP_SC_RD;
                            n_state = S_SC_T;
                        end
                    end
                    ACT_END_TEXT: begin
                        if (!r_built) n_status = ST_PHASE;
                        else n_end_text = 1'b1;
                    end
                    default: n_status = ST_PHASE;
                endcase
            end
            S_CLR: begin
                op = OP_CLR_ZERO;
                if (i_stat.cnt_last) n_state = S_CLR_FIN;
            end
            S_CLR_FIN: begin
                op      = OP_CLR_FIN;
                n_built = 1'b0;
                n_drop  = 1'b0;
                n_state = S_RESP;
            end
            S_INS_CHK: begin
                n_state = S_RESP;
                if (!i_stat.rd_zero) begin
                    op = OP_INS_STEP;
                end else if (i_stat.full) begin
                    n_drop   = 1'b1;
                    n_status = ST_FULL;
                end else begin
                    op      = OP_INS_ALLOC;
                    n_state = S_ROW_ZERO;
                end
            end
            S_ROW_ZERO: begin
                op = OP_ROW_ZERO;
                if (i_stat.cnt_last) n_state = S_RESP;
            end
            S_EP_WR: begin
                op      = OP_EP_WR;
                n_state = S_RESP;
            end
            S_B_ROOT_RD: begin
                op      = OP_B_ROOT_RD;
                n_state = S_B_ROOT_WR;
            end
            S_B_ROOT_WR: begin
                op      = OP_B_ROOT_WR;
                n_state = i_stat.cnt_last ? S_B_POP : S_B_ROOT_RD;
            end
            S_B_POP: begin
                if (i_stat.q_more) begin
                    op      = OP_B_POP;
                    n_state = S_B_U;
                end else begin
                    op      = OP_ICUR0;
                    n_built = 1'b1;
                    n_drop  = 1'b0;
                    n_state = S_RESP;
                end
            end
            S_B_U: begin
                op      = OP_B_U;
                n_state = S_B_F;
            end
            S_B_F: begin
                op      = OP_B_F;
                n_state = S_B_RD;
            end
            S_B_RD: begin
                op      = OP_B_RD;
                n_state = S_B_WR;
            end
            S_B_WR: begin
                op      = OP_B_WR;
                n_state = i_stat.cnt_last ? S_B_POP : S_B_RD;
            end
            S_SC_T: begin
                op      = OP_SC_T;
                n_state = S_SC_CHK;
            end
            S_SC_CHK: begin
                if (i_stat.t_zero) begin
                    op      = OP_SC_FIN;
                    n_state = S_RESP;
                end else begin
                    op      = OP_SC_ACC_RD;
                    n_state = S_SC_ACC;
                end
            end
            S_SC_ACC: begin
                op      = OP_SC_ACC;
                n_state = S_SC_CHK;
            end
            S_RESP: begin
                op      = OP_RESP;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.op       = op;
    assign o_cmd.status   = r_status;
    assign o_cmd.end_text = r_end_text;
    assign o_busy         = (r_state != S_IDLE);

endmodule

### sv/mpmc_dpath.sv
// ----------------------------------------------------------------------------
// mpmc_dpath
// Trie and automaton storage, cursors, counters and the result register.
// ----------------------------------------------------------------------------
module mpmc_dpath
    import mpmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [6:0] i_symbol,
    input  t_cmd       i_cmd,
    output t_dstat     o_stat,
    output logic       o_valid,
    output t_out_item  o_result
);

    logic [NODE_W-1:0] goto_mem [NODES*ALPHABET];
    logic [NODE_W-1:0] fail_mem [NODES];
    logic [15:0]       endc_mem [NODES];
    logic [NODE_W-1:0] bfsq_mem [NODES];

    logic [SYM_W-1:0]  r_sym, r_cnt;
    logic [NODE_W-1:0] r_icur, r_scur, r_u, r_f, r_t;
    logic [CNT_W-1:0]  r_ncnt, r_head, r_tail;
    logic [31:0]       r_total;
    logic [SUM_W-1:0]  r_sum;
    logic [15:0]       r_here;
    logic              r_valid;
    t_out_item         r_out;

    logic [NODE_W-1:0] r_ga, r_gb, r_fl, r_q;
    logic [15:0]       r_ec;

    logic              g_re_a, g_re_b, g_we;
    logic [G_AW-1:0]   g_addr_a, g_addr_b, g_waddr;
    logic [NODE_W-1:0] g_wdata;
    logic              ec_re, ec_we;
    logic [NODE_W-1:0] ec_raddr, ec_waddr;
    logic [15:0]       ec_wdata;
    logic              fl_re, fl_we;
    logic [NODE_W-1:0] fl_raddr, fl_waddr, fl_wdata;
    logic              q_re, q_we;
    logic [NODE_W-1:0] q_raddr, q_waddr, q_wdata;

    logic [32:0]       tot;
    logic [31:0]       tot_sat;
    logic [15:0]       sum_sat;

    assign tot     = {1'b0, r_total} + 33'(r_sum);
    assign tot_sat = tot[32] ? 32'hFFFF_FFFF : tot[31:0];
    assign sum_sat = (|r_sum[SUM_W-1:16]) ? 16'hFFFF : r_sum[15:0];

    always_comb begin
        g_re_a = 1'b0; g_addr_a = '0;
        g_re_b = 1'b0; g_addr_b = '0;
        g_we   = 1'b0; g_waddr  = '0; g_wdata = '0;
        ec_re  = 1'b0; ec_raddr = '0;
        ec_we  = 1'b0; ec_waddr = '0; ec_wdata = '0;
        fl_re  = 1'b0; fl_raddr = '0;
        fl_we  = 1'b0; fl_waddr = '0; fl_wdata = '0;
        q_re   = 1'b0; q_raddr  = '0;
        q_we   = 1'b0; q_waddr  = '0; q_wdata  = '0;
        case (i_cmd.op)
            OP_CLR_ZERO: begin
                g_we    = 1'b1;
                g_waddr = {NODE_W'(0), r_cnt};
            end
            OP_CLR_FIN: begin
                ec_we = 1'b1;
            end
            OP_INS_RD: begin
                g_re_a   = 1'b1;
                g_addr_a = {r_icur, r_sym};
            end
            OP_INS_ALLOC: begin
                g_we     = 1'b1;
                g_waddr  = {r_icur, r_sym};
                g_wdata  = r_ncnt[NODE_W-1:0];
                ec_we    = 1'b1;
                ec_waddr = r_ncnt[NODE_W-1:0];
            end
            OP_ROW_ZERO: begin
                g_we    = 1'b1;
                g_waddr = {r_icur, r_cnt};
            end
            OP_EP_RD: begin
                ec_re    = 1'b1;
                ec_raddr = r_icur;
            end
            OP_EP_WR: begin
                ec_we    = 1'b1;
                ec_waddr = r_icur;
                ec_wdata = (r_ec == 16'hFFFF) ? r_ec : r_ec + 16'd1;
            end
            OP_B_ROOT_RD: begin
                g_re_a   = 1'b1;
                g_addr_a = {NODE_W'(0), r_cnt};
            end
            OP_B_ROOT_WR: begin
                if (r_ga != '0) begin
                    fl_we    = 1'b1;
                    fl_waddr = r_ga;
                    q_we     = 1'b1;
                    q_waddr  = r_tail[NODE_W-1:0];
                    q_wdata  = r_ga;
                end
            end
            OP_B_POP: begin
                q_re    = 1'b1;
                q_raddr = r_head[NODE_W-1:0];
            end
            OP_B_U: begin
                fl_re    = 1'b1;
                fl_raddr = r_q;
            end
            OP_B_RD: begin
                g_re_a   = 1'b1;
                g_addr_a = {r_u, r_cnt};
                g_re_b   = 1'b1;
                g_addr_b = {r_f, r_cnt};
            end
            OP_B_WR: begin
                if (r_ga == '0) begin
                    g_we    = 1'b1;
                    g_waddr = {r_u, r_cnt};
                    g_wdata = r_gb;
                end else begin
                    fl_we    = 1'b1;
                    fl_waddr = r_ga;
                    fl_wdata = r_gb;
                    q_we     = 1'b1;
                    q_waddr  = r_tail[NODE_W-1:0];
                    q_wdata  = r_ga;
                end
            end
            OP_SC_RD: begin
                g_re_a   = 1'b1;
                g_addr_a = {r_scur, r_sym};
            end
            OP_SC_ACC_RD: begin
                ec_re    = 1'b1;
                ec_raddr = r_t;
                fl_re    = 1'b1;
                fl_raddr = r_t;
            end
            default: ;
        endcase
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (g_we) goto_mem[g_waddr] <= g_wdata;
        if (g_re_a) r_ga <= goto_mem[g_addr_a];
        if (g_re_b) r_gb <= goto_mem[g_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (ec_we) endc_mem[ec_waddr] <= ec_wdata;
        if (ec_re) r_ec <= endc_mem[ec_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) fail_mem[fl_waddr] <= fl_wdata;
        if (fl_re) r_fl <= fail_mem[fl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) bfsq_mem[q_waddr] <= q_wdata;
        if (q_re) r_q <= bfsq_mem[q_raddr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_sym  <= i_symbol[SYM_W-1:0];
                r_here <= '0;
            end
            OP_B_U:   r_u <= r_q;
            OP_B_F:   r_f <= r_fl;
            OP_SC_T: begin
                r_t   <= r_ga;
                r_sum <= '0;
            end
            OP_SC_ACC: begin
                r_sum <= r_sum + SUM_W'(r_ec);
                r_t   <= r_fl;
            end
            OP_SC_FIN: r_here <= sum_sat;
            OP_RESP: begin
                r_out.status       <= i_cmd.status;
                r_out.matches_here <= r_here;
                r_out.text_total   <= r_total;
                r_out.nodes_used   <= 11'(r_ncnt);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_icur  <= '0;
            r_scur  <= '0;
            r_ncnt  <= CNT_W'(1);
            r_head  <= '0;
            r_tail  <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (i_cmd.op)
                OP_LATCH:    r_cnt <= '0;
                OP_CLR_ZERO: r_cnt <= r_cnt + SYM_W'(1);
                OP_CLR_FIN: begin
                    r_ncnt  <= CNT_W'(1);
                    r_icur  <= '0;
                    r_scur  <= '0;
                    r_total <= '0;
                end
                OP_INS_STEP: r_icur <= r_ga;
                OP_INS_ALLOC: begin
                    r_icur <= r_ncnt[NODE_W-1:0];
                    r_ncnt <= r_ncnt + CNT_W'(1);
                    r_cnt  <= '0;
                end
                OP_ROW_ZERO: r_cnt <= r_cnt + SYM_W'(1);
                OP_EP_WR:    r_icur <= '0;
                OP_ICUR0:    r_icur <= '0;
                OP_B_INIT: begin
                    r_cnt  <= '0;
                    r_head <= '0;
                    r_tail <= '0;
                end
                OP_B_ROOT_WR: begin
                    r_cnt <= r_cnt + SYM_W'(1);
                    if (r_ga != '0) r_tail <= r_tail + CNT_W'(1);
                end
                OP_B_POP: r_head <= r_head + CNT_W'(1);
                OP_B_F:   r_cnt  <= '0;
                OP_B_WR: begin
                    r_cnt <= r_cnt + SYM_W'(1);
                    if (r_ga != '0) r_tail <= r_tail + CNT_W'(1);
                end
                OP_SC_T:   r_scur  <= r_ga;
                OP_SC_FIN: r_total <= tot_sat;
                OP_RESP: begin
                    r_valid <= 1'b1;
                    if (i_cmd.end_text) begin
                        r_total <= '0;
                        r_scur  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.rd_zero  = (r_ga == '0);
    assign o_stat.full     = (r_ncnt == CNT_W'(NODES));
    assign o_stat.cnt_last = (r_cnt == SYM_W'(ALPHABET - 1));
    assign o_stat.q_more   = (r_head < r_tail);
    assign o_stat.t_zero   = (r_t == '0);

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

### sv/multi_pattern_match_counter_core.sv
// ----------------------------------------------------------------------------
// multi_pattern_match_counter_core
// Aho-Corasick multi-pattern match counter, one word in, one result out.
// ----------------------------------------------------------------------------
// One word at a time: start is taken when busy is low, and exactly one result
// follows on o_result with o_valid high for one cycle; the receiver cannot
// stall it, and busy is already low in that cycle. After acceptance the
// sequencer steps the datapath through its storage: end text and refused
// actions go straight to the response, end pattern reads and rewrites the
// node's end count, insert reads a goto entry (and when a node is allocated
// zeroes its 128-entry goto row one entry a cycle), clear zeroes the root
// row, scan sums end counts along the failure chain, and build fills each
// node's goto row and failure link breadth-first. Issue a clear once after
// reset before inserting patterns; the goto table is not swept at reset.
// ----------------------------------------------------------------------------
module multi_pattern_match_counter_core
    import mpmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_result
);

    t_cmd   cmd;
    t_dstat stat;

    mpmc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    mpmc_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_symbol (i_item.symbol),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

### sv/mpmc_checker.sv
// ----------------------------------------------------------------------------
// mpmc_checker
// Port-level checks on the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module mpmc_checker
    import mpmc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_valid,
    input t_out_item o_result
);

    // a result only shows once the engine has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted word did not start work");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.status == ST_OK || o_result.status == ST_FULL ||
                     o_result.status == ST_PHASE))
        else $error("bad status code");

endmodule

bind multi_pattern_match_counter_core mpmc_checker u_chk (.*);
